### rtl/core/lcdseq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lcdseq_pkg
// Shared types and constants for the character LCD command sequencer.
// ============================================================================
package lcdseq_pkg;

    // Item kinds on the input stream (tuser)
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_STRING = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_MOVE   = 2'd3
    } t_cmd;

    // Running request
    typedef enum logic [1:0] {
        PROC_IDLE  = 2'd0,
        PROC_WRITE = 2'd1,
        PROC_CLEAR = 2'd2,
        PROC_MOVE  = 2'd3
    } t_proc;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLEAR        = 2'd0;
    localparam logic [1:0] CFG_FUNCTION_SET = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_CTRL = 2'd2;

    // Init sequence steps
    localparam logic [1:0] INIT_STEP_CLEAR = 2'd0;
    localparam logic [1:0] INIT_STEP_FUNC  = 2'd1;
    localparam logic [1:0] INIT_STEP_DISP  = 2'd2;

    // DDRAM address command bases per line
    localparam logic [7:0] LINE0_BASE = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'hC0;

    localparam logic [7:0] CLEAR_RESET      = 8'h01;
    localparam logic [7:0] FUNCTION_RESET   = 8'h38;
    localparam logic [7:0] DISPLAY_RESET    = 8'h0C;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

endpackage

### rtl/core/lcdseq_strbuf.sv
`timescale 1ns / 1ps
// ============================================================================
// lcdseq_strbuf
// String byte buffer: one write port, one registered read port.
// A read of the address written in the same cycle returns the new byte.
// ============================================================================
module lcdseq_strbuf
    import lcdseq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-first bypass
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/char_lcd_command_sequencer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// char_lcd_command_sequencer_core
// Sequences init commands, string writes, clears and cursor moves onto the
// RS/RW/E/data pins of an 8-bit character LCD, one pin update per tick.
// ============================================================================
// Results are registered into the output register, or the skid entry on a stall.
// Throughput: one item per cycle while the skid entry is empty; the buffer
//   read is prefetched for the current write index, so the only loop is
//   one state update per beat.
// Output: output register plus one skid entry; tready is a register.
// Reset (sync, active low) clears control state and the pin levels; the
//   string buffer needs no clearing, only bytes of the current string are read.
// ============================================================================
module char_lcd_command_sequencer_core
    import lcdseq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] char_byte, [8] line_select, [14:9] column_select, [15] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,  // last_byte
    input  logic [1:0]             i_s_axis_tuser,  // cmd
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] pin_rs, [1] pin_rw, [2] pin_enable, [10:3] data_bus,
    // [11] request_status, [12] done_res, [15:13] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_clear_cmd;
    logic [7:0] r_func_cmd;
    logic [7:0] r_disp_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_cmd <= CLEAR_RESET;
            r_func_cmd  <= FUNCTION_RESET;
            r_disp_cmd  <= DISPLAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLEAR:        r_clear_cmd <= i_cfg_data;
                CFG_FUNCTION_SET: r_func_cmd  <= i_cfg_data;
                CFG_DISPLAY_CTRL: r_disp_cmd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic       in_accept;
    t_cmd       in_cmd;
    logic [7:0] in_char;
    logic       in_line;
    logic [5:0] in_col;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd    = t_cmd'(i_s_axis_tuser);
    assign in_char   = i_s_axis_tdata[7:0];
    assign in_line   = i_s_axis_tdata[8];
    assign in_col    = i_s_axis_tdata[14:9];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_proc          r_proc,      n_proc;
    logic           r_init_done, n_init_done;
    logic [1:0]     r_init_step, n_init_step;
    logic           r_rs,        n_rs;
    logic           r_e,         n_e;
    logic [7:0]     r_bus,       n_bus;
    logic [LW-1:0]  r_len,       n_len;
    logic [LW-1:0]  r_pos,       n_pos;
    logic           r_collect,   n_collect;
    logic           r_line,      n_line;
    logic [5:0]     r_col,       n_col;

    logic           status;
    logic           done;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;
    logic [LW-1:0]  len_base;
    logic [7:0]     init_byte;
    logic [7:0]     move_byte;

    assign init_byte = (r_init_step == INIT_STEP_CLEAR) ? r_clear_cmd :
                       (r_init_step == INIT_STEP_FUNC)  ? r_func_cmd  : r_disp_cmd;
    assign move_byte = (r_line ? LINE1_BASE : LINE0_BASE) + {2'b00, r_col};
    assign len_base  = r_collect ? r_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc      <= PROC_IDLE;
            r_init_done <= 1'b0;
            r_init_step <= INIT_STEP_CLEAR;
            r_rs        <= 1'b0;
            r_e         <= 1'b0;
            r_bus       <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_collect   <= 1'b0;
            r_line      <= 1'b0;
            r_col       <= '0;
        end else begin
            r_proc      <= n_proc;
            r_init_done <= n_init_done;
            r_init_step <= n_init_step;
            r_rs        <= n_rs;
            r_e         <= n_e;
            r_bus       <= n_bus;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_collect   <= n_collect;
            r_line      <= n_line;
            r_col       <= n_col;
        end
    end

    always_comb begin
        n_proc      = r_proc;
        n_init_done = r_init_done;
        n_init_step = r_init_step;
        n_rs        = r_rs;
        n_e         = r_e;
        n_bus       = r_bus;
        n_len       = r_len;
        n_pos       = r_pos;
        n_collect   = r_collect;
        n_line      = r_line;
        n_col       = r_col;
        status      = 1'b0;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = len_base[AW-1:0];

        if (in_accept) begin
            unique case (in_cmd)
                CMD_TICK: begin
                    if (r_collect) begin
                        // ticks are ignored while a string is being collected
                    end else if (!r_init_done) begin
                        if (r_e) begin
                            n_e = 1'b0;
                            if (r_init_step == INIT_STEP_DISP) begin
                                n_init_done = 1'b1;
                                n_init_step = INIT_STEP_CLEAR;
                            end else begin
                                n_init_step = r_init_step + 2'd1;
                            end
                        end else begin
                            n_rs  = 1'b0;
                            n_bus = init_byte;
                            n_e   = 1'b1;
                        end
                    end else begin
                        unique case (r_proc)
                            PROC_WRITE: begin
                                if (r_e) begin
                                    n_e = 1'b0;
                                end else if (r_pos >= r_len) begin
                                    n_pos  = '0;
                                    n_proc = PROC_IDLE;
                                    done   = 1'b1;
                                end else begin
                                    n_rs  = 1'b1;
                                    n_bus = rd_data;
                                    n_e   = 1'b1;
                                    n_pos = r_pos + LW'(1);
                                end
                            end
                            PROC_CLEAR, PROC_MOVE: begin
                                if (r_e) begin
                                    n_e    = 1'b0;
                                    n_proc = PROC_IDLE;
                                    done   = 1'b1;
                                end else begin
                                    n_rs  = 1'b0;
                                    n_bus = (r_proc == PROC_CLEAR) ? r_clear_cmd : move_byte;
                                    n_e   = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_STRING: begin
                    if (r_collect || (r_proc == PROC_IDLE)) begin
                        n_collect = 1'b1;
                        n_len     = len_base;
                        if (len_base < DEPTH_L) begin
                            wr_en = 1'b1;
                            n_len = len_base + LW'(1);
                        end
                        if (i_s_axis_tlast) begin
                            n_collect = 1'b0;
                            n_pos     = '0;
                            n_proc    = PROC_WRITE;
                        end
                    end else begin
                        status = 1'b1;
                    end
                end
                CMD_CLEAR, CMD_MOVE: begin
                    if (!r_collect && (r_proc == PROC_IDLE)) begin
                        if (in_cmd == CMD_CLEAR) begin
                            n_proc = PROC_CLEAR;
                        end else begin
                            n_line = in_line;
                            n_col  = in_col;
                            n_proc = PROC_MOVE;
                        end
                    end else begin
                        status = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Prefetch the byte at the next write index so it is ready on the next tick.
    assign rd_addr = (n_pos < DEPTH_L) ? n_pos[AW-1:0] : '0;

    lcdseq_strbuf #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_strbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_char),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic [OUT_TDATA_W-1:0] beat;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_skid_valid;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic                   out_take;

    assign beat = {3'b000, done, status, n_bus, n_e, 1'b0, n_rs};
    assign out_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_accept) begin
                r_out_data <= beat;
            end
        end else if (in_accept) begin
            r_skid_data <= beat;
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    a_collect_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collect |-> (r_proc == PROC_IDLE))
        else $error("string collection while a request runs");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_proc == PROC_WRITE) |-> (r_pos <= r_len))
        else $error("write index past string length");

    a_done_e_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[12]) |-> !o_m_axis_tdata[2])
        else $error("done reported with E high");

    a_done_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && done) |=> (r_proc == PROC_IDLE) && !r_e)
        else $error("done without returning to idle");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the character LCD command sequencer core. Every beat
// is run through a cycle-free model of the pin sequencer (init strobes,
// string writes, clears, cursor moves, busy answers) and the expected pin
// snapshot is queued. Each result beat is checked field by field against
// the oldest queued snapshot. A directed table comes first, followed by
// well-formed request sequences with random content and some noise, under
// several source-gap and sink-stall mixes and several command byte settings.
// ============================================================================
module tb;
    import lcdseq_pkg::*;

    localparam int BUF_DEPTH   = 256;
    localparam int STALL_LIMIT = 2000;   // cycles without any accepted beat
    localparam int PHASE_BEATS = 210;
    localparam int MAX_PRINTS  = 100;

    // one input beat, unpacked into its fields
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
        logic       last;
        logic       line;
        logic [5:0] col;
    } t_lcd_req;

    // result tdata layout, MSB first
    typedef struct packed {
        logic [2:0] pad;
        logic       done;
        logic       busy;
        logic [7:0] bus;
        logic       en;
        logic       rw;
        logic       rs;
    } t_lcd_pins;

    typedef struct packed {
        t_lcd_req  req;
        logic      typed;    // 1: use the pin snapshot below as is
        t_lcd_pins pins;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [15:0] s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic [1:0]  s_tuser     = CMD_TICK;
    logic        m_tready    = 1'b1;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = CFG_CLEAR;
    logic [7:0]  cfg_data    = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    // traffic shaping, percent per cycle
    int idle_pct  = 0;
    int stall_pct = 0;

    int fail_count  = 0;
    int result_idx  = 0;
    int quiet_count = 0;

    t_lcd_pins pin_updates_q[$];

    // ---- model state ----
    logic [7:0] cmd_clear, cmd_func, cmd_disp;
    t_proc      run_proc;
    logic       init_fin;
    logic [1:0] init_idx;
    logic       pin_rs_q, pin_en_q;
    logic [7:0] bus_q;
    logic [7:0] text_mem [BUF_DEPTH];
    int         text_len, text_pos;
    logic       gathering;
    logic       line_q;
    logic [5:0] col_q;

    char_lcd_command_sequencer_core #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Config clear FF, function set 00, display control A5 during this table.
    // Pin snapshot: '{pad, done, busy, bus, en, rw, rs}
    localparam t_dir_row DIR_TAB [26] = '{
        // move before init ends: queued, pins still at reset
        '{'{CMD_MOVE,   8'h00, 1'b0, 1'b1, 6'd63}, 1'b1, '{3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        // busy while the move waits
        '{'{CMD_CLEAR,  8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_STRING, 8'h55, 1'b1, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
        // init: clear, function set, display control
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'hA5, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'hA5, 1'b0, 1'b0, 1'b0}},
        // queued move: line 1 column 63 gives C0 + 3F
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b1, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_MOVE,   8'hFF, 1'b1, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        // two-byte string; clear is refused and ticks do nothing meanwhile
        '{'{CMD_STRING, 8'h00, 1'b0, 1'b1, 6'd63}, 1'b0, '0},
        '{'{CMD_CLEAR,  8'h00, 1'b0, 1'b0, 6'd0},  1'b1, '{3'd0, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_STRING, 8'hFF, 1'b1, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_CLEAR,  8'h00, 1'b1, 1'b1, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0},
        '{'{CMD_TICK,   8'h00, 1'b0, 1'b0, 6'd0},  1'b0, '0}
    };

    // ---- pin sequencer model ----

    // One strobe phase: E rises with rs/byte, or falls. Returns 1 on the fall.
    function automatic logic strobe_phase(input logic rs, input logic [7:0] byte_v);
        if (pin_en_q) begin
            pin_en_q = 1'b0;
            return 1'b1;
        end
        pin_rs_q = rs;
        bus_q    = byte_v;
        pin_en_q = 1'b1;
        return 1'b0;
    endfunction

    function automatic t_lcd_pins lcd_pins_predict(input t_lcd_req r);
        t_lcd_pins  p;
        logic       done;
        logic       busy;
        logic [7:0] init_byte;
        done = 1'b0;
        busy = 1'b0;
        case (r.cmd)
            CMD_TICK: begin
                if (gathering) begin
                    // tick swallowed while a string is being collected
                end else if (!init_fin) begin
                    init_byte = (init_idx == INIT_STEP_CLEAR) ? cmd_clear :
                                (init_idx == INIT_STEP_FUNC)  ? cmd_func  : cmd_disp;
                    if (strobe_phase(1'b0, init_byte)) begin
                        if (init_idx == INIT_STEP_DISP) begin
                            init_fin = 1'b1;
                            init_idx = INIT_STEP_CLEAR;
                        end else begin
                            init_idx = init_idx + 2'd1;
                        end
                    end
                end else begin
                    case (run_proc)
                        PROC_WRITE: begin
                            if (pin_en_q) begin
                                pin_en_q = 1'b0;
                            end else if (text_pos >= text_len) begin
                                text_pos = 0;
                                run_proc = PROC_IDLE;
                                done     = 1'b1;
                            end else begin
                                void'(strobe_phase(1'b1, text_mem[text_pos]));
                                text_pos++;
                            end
                        end
                        PROC_CLEAR: begin
                            if (strobe_phase(1'b0, cmd_clear)) begin
                                run_proc = PROC_IDLE;
                                done     = 1'b1;
                            end
                        end
                        PROC_MOVE: begin
                            if (strobe_phase(1'b0, (line_q ? LINE1_BASE : LINE0_BASE)
                                                   + {2'b00, col_q})) begin
                                run_proc = PROC_IDLE;
                                done     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_STRING: begin
                if (gathering || run_proc == PROC_IDLE) begin
                    if (!gathering) begin
                        gathering = 1'b1;
                        text_len  = 0;
                    end
                    // overflow bytes are dropped but still accepted
                    if (text_len < BUF_DEPTH) begin
                        text_mem[text_len] = r.ch;
                        text_len++;
                    end
                    if (r.last) begin
                        gathering = 1'b0;
                        text_pos  = 0;
                        run_proc  = PROC_WRITE;
                    end
                end else begin
                    busy = 1'b1;
                end
            end
            default: begin
                if (!gathering && run_proc == PROC_IDLE) begin
                    if (r.cmd == CMD_CLEAR) begin
                        run_proc = PROC_CLEAR;
                    end else begin
                        line_q   = r.line;
                        col_q    = r.col;
                        run_proc = PROC_MOVE;
                    end
                end else begin
                    busy = 1'b1;
                end
            end
        endcase
        p      = '0;
        p.done = done;
        p.busy = busy;
        p.bus  = bus_q;
        p.en   = pin_en_q;
        p.rs   = pin_rs_q;
        return p;
    endfunction

    // ---- checking ----

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("ERROR: %s", msg);
    endtask

    task automatic cmp_field(input string name, input int got, input int want);
        if (got != want)
            log_mismatch($sformatf("beat %0d %s got 0x%0h exp 0x%0h",
                                   result_idx, name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_lcd_pins got;
        t_lcd_pins want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = o_m_axis_tdata;
            if (pin_updates_q.size() == 0) begin
                log_mismatch($sformatf("beat %0d arrived with nothing expected", result_idx));
            end else begin
                want = pin_updates_q.pop_front();
                cmp_field("pin_rs",         int'(got.rs),   int'(want.rs));
                cmp_field("pin_rw",         int'(got.rw),   int'(want.rw));
                cmp_field("pin_enable",     int'(got.en),   int'(want.en));
                cmp_field("data_bus",       int'(got.bus),  int'(want.bus));
                cmp_field("request_status", int'(got.busy), int'(want.busy));
                cmp_field("done_res",       int'(got.done), int'(want.done));
                cmp_field("zero pad",       int'(got.pad),  int'(want.pad));
            end
            result_idx++;
        end
    end

    // sink side stalls
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ---- stimulus ----

    // Source side: optional gap, then hold the beat until accepted.
    // typed=1 queues the given snapshot instead of the model's.
    task automatic send_beat(input t_lcd_req r, input logic typed, input t_lcd_pins pins);
        t_lcd_pins exp_pins;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        s_tdata  <= {1'b0, r.col, r.line, r.ch};
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_pins = lcd_pins_predict(r);
        pin_updates_q.push_back(typed ? pins : exp_pins);
    endtask

    function automatic t_lcd_req any_req(input t_cmd c);
        t_lcd_req r;
        r.cmd  = c;
        r.ch   = 8'($urandom_range(255));
        r.last = 1'($urandom_range(1));
        r.line = 1'($urandom_range(1));
        r.col  = 6'($urandom_range(63));
        return r;
    endfunction

    // Source stops and waits for every outstanding result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pin_updates_q.size() != 0);
    endtask

    task automatic load_commands(input logic [7:0] clr, input logic [7:0] fn,
                                 input logic [7:0] disp);
        logic [1:0] idx  [3];
        logic [7:0] vals [3];
        idx  = '{CFG_CLEAR, CFG_FUNCTION_SET, CFG_DISPLAY_CTRL};
        vals = '{clr, fn, disp};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_CLEAR:        cmd_clear = vals[k];
                CFG_FUNCTION_SET: cmd_func  = vals[k];
                default:          cmd_disp  = vals[k];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // n ticks with don't-care fields, sprinkled with stray requests
    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 5)
                send_beat(any_req(t_cmd'($urandom_range(3))), 1'b0, '0);
            send_beat(any_req(CMD_TICK), 1'b0, '0);
        end
    endtask

    // string of len bytes, then enough ticks to write it out
    task automatic send_text(input int len);
        t_lcd_req r;
        int       stored;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 5)
                send_beat(any_req($urandom_range(1) ? CMD_TICK : CMD_CLEAR), 1'b0, '0);
            r      = any_req(CMD_STRING);
            r.last = (k == len - 1);
            send_beat(r, 1'b0, '0);
        end
        stored = (len < BUF_DEPTH) ? len : BUF_DEPTH;
        send_ticks(2 * stored + $urandom_range(1, 3));
    endtask

    task automatic run_traffic(input int quota);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = $urandom_range(1, 24);
                send_text(len);
                sent += 3 * len + 1;
            end else if (pick < 65) begin
                send_beat(any_req(CMD_CLEAR), 1'b0, '0);
                send_ticks($urandom_range(2, 4));
                sent += 4;
            end else if (pick < 85) begin
                send_beat(any_req(CMD_MOVE), 1'b0, '0);
                send_ticks($urandom_range(2, 4));
                sent += 4;
            end else if (pick < 97) begin
                send_beat(any_req(t_cmd'($urandom_range(3))), 1'b0, '0);
                sent++;
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin
        // model state after reset
        cmd_clear = CLEAR_RESET;
        cmd_func  = FUNCTION_RESET;
        cmd_disp  = DISPLAY_RESET;
        run_proc  = PROC_IDLE;
        init_fin  = 1'b0;
        init_idx  = INIT_STEP_CLEAR;
        pin_rs_q  = 1'b0;
        pin_en_q  = 1'b0;
        bus_q     = '0;
        text_len  = 0;
        text_pos  = 0;
        gathering = 1'b0;
        line_q    = 1'b0;
        col_q     = '0;
        foreach (text_mem[k]) text_mem[k] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // init sequence below runs with these bytes
        load_commands(8'hFF, 8'h00, 8'hA5);

        foreach (DIR_TAB[k])
            send_beat(DIR_TAB[k].req, DIR_TAB[k].typed, DIR_TAB[k].pins);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            drain_results();
            repeat (4) @(posedge i_clk);
            case (phase)
                0: load_commands(8'hFF, 8'h00, 8'hA5);
                1: load_commands(8'h00, 8'hFF, 8'h00);
                2: load_commands(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
                default: load_commands(CLEAR_RESET, FUNCTION_RESET, DISPLAY_RESET);
            endcase
            // one string past the buffer size: the tail is dropped
            if (phase == 0)
                send_text($urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 14));
            run_traffic(PHASE_BEATS);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pin_updates_q.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pin_updates_q.size()));
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
